@@ hdl/aaf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aaf_pkg
// Shared types, constants and the ADTS header byte builder for the
// RTP/AAC to ADTS framer.
// ----------------------------------------------------------------------------
package aaf_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_MPEG_VERSION_ID   = 8'd0;
  localparam logic [7:0] CFG_PROFILE_CODE      = 8'd1;
  localparam logic [7:0] CFG_SAMPLE_RATE_INDEX = 8'd2;
  localparam logic [7:0] CFG_CHANNEL_CONFIG    = 8'd3;

  // Packet offsets
  localparam logic [3:0] POS_LEN = 4'd12;  // AU length byte
  localparam logic [3:0] POS_ESC = 4'd13;  // escape continuation byte
  localparam logic [3:0] POS_MAX = 4'd15;  // saturation point

  localparam logic [7:0]  LEN_ESCAPE    = 8'hFF;
  localparam logic [12:0] FLEN_ADD      = 13'd7;    // header size
  localparam logic [12:0] FLEN_ADD_ESC  = 13'd262;  // 255 + header size

  localparam logic [2:0] HDR_LAST = 3'd6;  // index of the seventh header byte

  typedef struct packed {
    logic       mpeg_version_id;
    logic [1:0] profile_code;
    logic [3:0] sample_rate_index;
    logic [2:0] channel_config;
  } aaf_cfg_t;

  // One pending piece of work for the emitter
  typedef struct packed {
    logic        is_header;  // 1: emit seven header bytes, 0: pass one byte
    logic [12:0] flen;
    logic [7:0]  data;
    logic        last;
  } aaf_work_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx,
                                          input aaf_cfg_t cfg,
                                          input logic [12:0] flen);
    logic [7:0] b;
    b = 8'hFC;
    unique case (idx)
      3'd0: b = 8'hFF;
      3'd1: b = {4'hF, cfg.mpeg_version_id, 2'b00, 1'b1};
      // private bit sits between rate index and channel MSB
      3'd2: b = {cfg.profile_code, cfg.sample_rate_index, 1'b0, cfg.channel_config[2]};
      3'd3: b = {cfg.channel_config[1:0], 4'b0000, flen[12:11]};
      3'd4: b = flen[10:3];
      3'd5: b = {flen[2:0], 5'h1F};
      default: b = 8'hFC;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ hdl/aaf_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aaf_parse
// Tracks the byte offset, decodes the AU length and registers one work item.
// ----------------------------------------------------------------------------
module aaf_parse (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output logic                   work_valid,
  output aaf_pkg::aaf_work_t     work,
  input  wire logic              work_take
);
  import aaf_pkg::*;

  logic [3:0] pos;
  logic       escape_seen;
  logic [3:0] pos_next;
  logic       escape_next;
  logic       accept;
  logic       has_work;
  aaf_work_t  work_next;

  assign in_ready = !work_valid || work_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    has_work            = 1'b0;
    escape_next         = escape_seen;
    work_next.is_header = 1'b0;
    work_next.flen      = {5'b0, data_byte} + FLEN_ADD;
    work_next.data      = data_byte;
    work_next.last      = last_byte;
    priority if (pos == POS_LEN) begin
      if (data_byte == LEN_ESCAPE) begin
        escape_next = 1'b1;
      end else begin
        has_work            = 1'b1;
        work_next.is_header = 1'b1;
      end
    end else if (pos == POS_ESC && escape_seen) begin
      has_work            = 1'b1;
      work_next.is_header = 1'b1;
      work_next.flen      = {5'b0, data_byte} + FLEN_ADD_ESC;
    end else if (pos > POS_LEN) begin
      has_work = 1'b1;
    end else begin
      has_work = 1'b0;
    end
    if (last_byte) begin
      pos_next    = '0;
      escape_next = 1'b0;
    end else if (pos < POS_MAX) begin
      pos_next = pos + 4'd1;
    end else begin
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      escape_seen <= 1'b0;
      work_valid  <= 1'b0;
    end else begin
      if (accept) begin
        pos         <= pos_next;
        escape_seen <= escape_next;
        work_valid  <= has_work;
      end else if (work_take) begin
        work_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work <= work_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/aaf_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aaf_emit
// Expands a work item into header bytes or one payload byte and drives the
// output register.
// ----------------------------------------------------------------------------
module aaf_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire aaf_pkg::aaf_cfg_t cfg,
  input  wire logic              work_valid,
  input  wire aaf_pkg::aaf_work_t work,
  output logic                   work_take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic                   from_header
);
  import aaf_pkg::*;

  logic [2:0] hdr_idx;
  logic       load;
  logic       hdr_done;

  assign load      = work_valid && (!out_valid || out_ready);
  assign hdr_done  = (hdr_idx == HDR_LAST);
  assign work_take = load && (!work.is_header || hdr_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (work.is_header) begin
          hdr_idx <= hdr_done ? 3'd0 : hdr_idx + 3'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      from_header <= work.is_header;
      if (work.is_header) begin
        out_byte <= hdr_byte(hdr_idx, cfg, work.flen);
        out_last <= hdr_done && work.last;
      end else begin
        out_byte <= work.data;
        out_last <= work.last;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/rtp_aac_to_adts_framer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_aac_to_adts_framer
// Strips the RTP header from an AAC packet, prepends a 7-byte ADTS header
// built from the AU length and the config registers, and passes the payload.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                  | Direction
//  --------+------------------------------------------+----------
//  in      | in_valid/in_ready, data_byte, last_byte  | sink
//  out     | out_valid/out_ready, out_byte, out_last, | source
//          | from_header                              |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | sink
//
// Payload and RTP header bytes pass at one transfer per cycle while out_ready
// is high; the byte that completes the AU length holds the emitter while it
// sends the seven header bytes, one at a time, through the single output
// register. Input work register and output register each hold one item, so
// a new byte is taken while the previous result waits. Reset clears offset,
// escape flag, valids and loads the register defaults. Stalls on out_ready
// back up through both registers. cfg is always ready.
//
module rtp_aac_to_adts_framer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            from_header,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import aaf_pkg::*;

  aaf_cfg_t  cfg;
  aaf_work_t work;
  logic      work_valid;
  logic      work_take;

  assign cfg_ready = 1'b1;

  // Config registers: only low bits kept, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mpeg_version_id   <= 1'b1;
      cfg.profile_code      <= 2'd1;
      cfg.sample_rate_index <= 4'd4;
      cfg.channel_config    <= 3'd2;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MPEG_VERSION_ID)   cfg.mpeg_version_id   <= cfg_data[0];
      if (cfg_index == CFG_PROFILE_CODE)      cfg.profile_code      <= cfg_data[1:0];
      if (cfg_index == CFG_SAMPLE_RATE_INDEX) cfg.sample_rate_index <= cfg_data[3:0];
      if (cfg_index == CFG_CHANNEL_CONFIG)    cfg.channel_config    <= cfg_data[2:0];
    end
  end

  // Offset tracking and length decode
  aaf_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .work_valid (work_valid),
    .work       (work),
    .work_take  (work_take)
  );

  // Header expansion and output register
  aaf_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .work_valid  (work_valid),
    .work        (work),
    .work_take   (work_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .from_header (from_header)
  );

endmodule
`default_nettype wire
